### src/grid_square_coverage_counter_defines.svh
// Assertion macros for the grid square coverage counter.
`ifndef GRID_SQUARE_COVERAGE_COUNTER_DEFINES_SVH
`define GRID_SQUARE_COVERAGE_COUNTER_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define GSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
// Assert that a condition holds at every clock edge out of reset.
`define GSC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`endif

### src/gscc_pkg.sv
// Package with shared types and constants of the grid square coverage counter.
`timescale 1ns / 1ps
package gscc_pkg;
  localparam int unsigned MaxGrid   = 256;
  localparam int unsigned FifoDepth = 64;
  localparam int unsigned FullQ8    = 25600;

  localparam logic [1:0] OpClear  = 2'd0;
  localparam logic [1:0] OpMark   = 2'd1;
  localparam logic [1:0] OpPacket = 2'd2;
  localparam logic [1:0] OpFinish = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegGrid   = 2'd0;
  localparam logic [1:0] RegRadius = 2'd1;
  localparam logic [1:0] RegLimit  = 2'd2;

  localparam logic [8:0] GridReset   = 9'd100;
  localparam logic [7:0] RadiusReset = 8'd15;
  localparam logic [6:0] LimitReset  = 7'd64;

  typedef struct packed {
    logic [1:0] opcode;
    logic [8:0] x_pos;
    logic [8:0] y_pos;
  } cmd_t;

  typedef struct packed {
    logic [16:0] global_cells;
    logic [16:0] buffered_cells;
    logic [14:0] global_percent;
    logic [14:0] buffered_percent;
    logic [14:0] relative_percent;
    logic        relative_valid;
  } res_t;

  // Quotient request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [16:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;
endpackage

### src/gscc_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gscc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gscc_pkg::div_req_t req_i,
  output gscc_pkg::div_rsp_t rsp_o
);
  import gscc_pkg::*;
  logic [31:0] quo_q, quo_d;
  logic [17:0] rem_q, rem_d;
  logic [16:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [17:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[16:0], quo_q[31]};
    if (req_i.start) begin
      quo_d = req_i.num; rem_d = '0; den_d = req_i.den;
      cnt_d = 6'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule

### src/grid_square_coverage_counter.sv
// Top level of the grid square coverage counter.
`timescale 1ns / 1ps
// Command block over two 1-bit coverage maps held in synchronous RAMs plus a
// small position FIFO RAM. busy is high from the accepted start until the
// command finishes, but Packet never raises it; results cannot be
// stalled and appear for one cycle on done_o. Clear sweeps MaxGrid*MaxGrid
// cells, one cell of each map per cycle. Mark passes a setup state, then
// writes one cell per cycle over the clipped square, (2*radius)^2 cells at
// most. Packet is taken in the idle state, so the next command can follow at
// once. Finish drains the queued positions, the newest up to the limit, each
// through StFifoRd, StFifoLd and StSqSet and then its square, then counts the
// grid g*g cells at one cell per cycle plus a flush state, then runs up to
// three divisions on the shared divider, and registers the result in StOut
// after the last quotient. After reset the maps are swept clear before the
// first command is taken; configuration writes are taken during that time.
`include "grid_square_coverage_counter_defines.svh"
module grid_square_coverage_counter #(
  parameter int unsigned MAX_GRID   = gscc_pkg::MaxGrid,
  parameter int unsigned FIFO_DEPTH = gscc_pkg::FifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  gscc_pkg::cmd_t      cmd_i,
  output logic                busy_o,
  output logic                done_o,
  output gscc_pkg::res_t      res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import gscc_pkg::*;
  localparam int unsigned CW = $clog2(MAX_GRID);
  localparam int unsigned AW = 2 * CW;
  localparam int unsigned FW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned NW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned KW = AW + 1;
  localparam logic [AW-1:0] LastAddr = '1;

  // wrap a FIFO index that is below twice the depth
  function automatic logic [FW-1:0] wrap_idx(input logic [31:0] v);
    if (v >= 32'(FIFO_DEPTH)) return FW'(v - 32'(FIFO_DEPTH));
    return FW'(v);
  endfunction

  typedef enum logic [3:0] {
    StInit, StIdle, StSqSet, StSqRun, StFifoRd, StFifoLd, StCnt, StCntFlush,
    StDiv0, StDiv1, StDiv2, StDiv3, StDivW, StOut
  } state_e;

  // registers
  logic [8:0] grid_q; logic [7:0] radius_q; logic [6:0] limit_q;
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GridReset; radius_q <= RadiusReset; limit_q <= LimitReset;
    end else if (cfg_we) begin
      case (paddr[3:2])
        RegGrid: grid_q <= pwdata[8:0];
        RegRadius: radius_q <= pwdata[7:0];
        RegLimit: limit_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      RegGrid: prdata = {23'd0, grid_q};
      RegRadius: prdata = {24'd0, radius_q};
      RegLimit: prdata = {25'd0, limit_q};
      default: prdata = '0;
    endcase
  end

  logic [10:0] geff, leff;
  always_comb begin
    if (grid_q == 9'd0) geff = 11'd1;
    else if (32'(grid_q) > MAX_GRID) geff = 11'(MAX_GRID);
    else geff = {2'b0, grid_q};
    if (limit_q == 7'd0) leff = 11'd1;
    else if (32'(limit_q) > FIFO_DEPTH) leff = 11'(FIFO_DEPTH);
    else leff = {4'b0, limit_q};
  end

  // memories
  logic gmap [2**AW]; logic bmap [2**AW];
  logic [17:0] fifo_mem [FIFO_DEPTH];
  logic g_we, b_we, g_wd, b_wd;
  logic [AW-1:0] m_wa, m_ra;
  logic g_rd_q, b_rd_q;
  always_ff @(posedge clk_i) begin
    if (g_we) gmap[m_wa] <= g_wd;
    if (b_we) bmap[m_wa] <= b_wd;
    g_rd_q <= gmap[m_ra];
    b_rd_q <= bmap[m_ra];
  end
  logic f_we; logic [FW-1:0] f_wa, f_ra; logic [17:0] f_wd, f_rd_q;
  always_ff @(posedge clk_i) begin
    if (f_we) fifo_mem[f_wa] <= f_wd;
    f_rd_q <= fifo_mem[f_ra];
  end

  state_e st_q;
  logic [AW-1:0] addr_q;
  logic [10:0] xb_q, ya_q, yb_q, xi_q, yi_q;
  logic [8:0] px_q, py_q;
  logic sel_b_q;
  logic [FW-1:0] head_q, rd_q;
  logic [NW-1:0] cnt_q, left_q;
  logic [KW-1:0] gc_q, bc_q;
  logic cnt_vld_q;
  logic [31:0] q0_q, q1_q, q2_q;
  res_t res_q; logic done_q;
  div_req_t dreq; div_rsp_t drsp;

  gscc_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // square bounds from the held position
  logic [10:0] x0, y0, x1, y1;
  always_comb begin
    x0 = (px_q > {1'b0, radius_q}) ? 11'(px_q - {1'b0, radius_q}) : 11'd0;
    y0 = (py_q > {1'b0, radius_q}) ? 11'(py_q - {1'b0, radius_q}) : 11'd0;
    x1 = 11'(px_q) + 11'(radius_q);
    y1 = 11'(py_q) + 11'(radius_q);
    if (x1 > geff) x1 = geff;
    if (y1 > geff) y1 = geff;
  end

  logic [FW-1:0] skip_idx;
  logic [NW-1:0] skip_n;
  always_comb begin
    skip_n = (11'(cnt_q) > leff) ? NW'(11'(cnt_q) - leff) : '0;
    skip_idx = wrap_idx(32'(head_q) + 32'(skip_n));
  end

  logic [31:0] total;
  assign total = 32'(geff) * 32'(geff);
  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (st_q != StIdle);

  always_comb begin
    g_we = 1'b0; b_we = 1'b0; g_wd = 1'b0; b_wd = 1'b0;
    m_wa = addr_q; m_ra = addr_q;
    f_we = 1'b0; f_wa = wrap_idx(32'(head_q) + 32'(cnt_q));
    f_wd = {cmd_i.x_pos, cmd_i.y_pos}; f_ra = rd_q;
    dreq = '0;
    case (st_q)
      StInit: begin g_we = 1'b1; b_we = 1'b1; end
      StSqRun: begin
        m_wa = {xi_q[CW-1:0], yi_q[CW-1:0]};
        g_wd = 1'b1; b_wd = 1'b1;
        g_we = !sel_b_q; b_we = sel_b_q;
      end
      StCnt: m_ra = {xi_q[CW-1:0], yi_q[CW-1:0]};
      StDiv0: begin dreq.start = 1'b1; dreq.num = 32'(gc_q) * FullQ8;
        dreq.den = 17'(total); end
      StDiv1: if (drsp.done) begin dreq.start = 1'b1;
        dreq.num = 32'(bc_q) * FullQ8; dreq.den = 17'(total); end
      StDiv2: if (drsp.done) begin dreq.start = (gc_q != '0);
        dreq.num = 32'(bc_q) * FullQ8; dreq.den = 17'(gc_q); end
      default: ;
    endcase
    if (st_q == StIdle && accept && cmd_i.opcode == OpPacket) f_we = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StInit; addr_q <= '0; head_q <= '0; cnt_q <= '0; done_q <= 1'b0;
      cnt_vld_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        StInit: begin
          addr_q <= addr_q + AW'(1);
          if (addr_q == LastAddr) st_q <= StIdle;
        end
        StIdle: if (accept) begin
          px_q <= cmd_i.x_pos; py_q <= cmd_i.y_pos;
          case (cmd_i.opcode)
            OpClear: begin addr_q <= '0; head_q <= '0; cnt_q <= '0; st_q <= StInit; end
            OpMark: begin sel_b_q <= 1'b0; st_q <= StSqSet; end
            OpPacket: begin
              // drop oldest entries until the new one fits
              if (11'(cnt_q) >= leff) begin
                head_q <= wrap_idx(32'(head_q) + 32'(cnt_q) + 32'd1 - 32'(leff));
                cnt_q <= NW'(leff);
              end else cnt_q <= cnt_q + NW'(1);
            end
            default: begin
              sel_b_q <= 1'b1; rd_q <= skip_idx; left_q <= cnt_q - skip_n;
              st_q <= StFifoRd;
            end
          endcase
        end
        StFifoRd: begin
          if (left_q == '0) begin
            head_q <= '0; cnt_q <= '0; addr_q <= '0; gc_q <= '0; bc_q <= '0;
            xi_q <= '0; yi_q <= '0; cnt_vld_q <= 1'b0; st_q <= StCnt;
          end else st_q <= StFifoLd;
        end
        StFifoLd: begin
          px_q <= f_rd_q[17:9]; py_q <= f_rd_q[8:0];
          rd_q <= wrap_idx(32'(rd_q) + 32'd1); left_q <= left_q - NW'(1);
          st_q <= StSqSet;
        end
        StSqSet: begin
          xb_q <= x0 < x1 ? x1 : x1; ya_q <= y0; yb_q <= y1; xi_q <= x0; yi_q <= y0;
          if (x0 < x1 && y0 < y1) st_q <= StSqRun;
          else st_q <= sel_b_q ? StFifoRd : StIdle;
        end
        StSqRun: begin
          if (yi_q + 11'd1 < yb_q) yi_q <= yi_q + 11'd1;
          else begin
            yi_q <= ya_q;
            if (xi_q + 11'd1 < xb_q) xi_q <= xi_q + 11'd1;
            else st_q <= sel_b_q ? StFifoRd : StIdle;
          end
        end
        StCnt: begin
          cnt_vld_q <= 1'b1;
          if (cnt_vld_q) begin
            gc_q <= gc_q + KW'(g_rd_q); bc_q <= bc_q + KW'(b_rd_q);
          end
          if (yi_q + 11'd1 < geff) yi_q <= yi_q + 11'd1;
          else begin
            yi_q <= '0;
            if (xi_q + 11'd1 < geff) xi_q <= xi_q + 11'd1;
            else st_q <= StCntFlush;
          end
        end
        StCntFlush: begin
          // take the read issued in the last scan cycle
          if (cnt_vld_q) begin
            gc_q <= gc_q + KW'(g_rd_q); bc_q <= bc_q + KW'(b_rd_q);
          end
          cnt_vld_q <= 1'b0;
          if (!cnt_vld_q) st_q <= StDiv0;
        end
        StDiv0: st_q <= StDiv1;
        StDiv1: if (drsp.done) begin q0_q <= drsp.quo; st_q <= StDiv2; end
        StDiv2: if (drsp.done) begin
          q1_q <= drsp.quo;
          st_q <= (gc_q != '0) ? StDiv3 : StOut;
          q2_q <= '0;
        end
        StDiv3: if (drsp.done) begin q2_q <= drsp.quo; st_q <= StOut; end
        StOut: begin
          res_q.global_cells <= 17'(gc_q);
          res_q.buffered_cells <= 17'(bc_q);
          res_q.global_percent <= q0_q[14:0];
          res_q.buffered_percent <= q1_q[14:0];
          res_q.relative_percent <= (q2_q > FullQ8) ? 15'(FullQ8) : q2_q[14:0];
          res_q.relative_valid <= (gc_q != '0);
          done_q <= 1'b1; st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end
  assign done_o = done_q;
  assign res_o = res_q;

  `GSC_ASSERT_NEXT(a_done_one, clk_i, rst_ni, done_q, !done_q)
  `GSC_ASSERT_NEXT(a_out_done, clk_i, rst_ni, st_q == StOut, done_q && st_q == StIdle)
  `GSC_ASSERT_ALWAYS(a_fifo_cnt, clk_i, rst_ni, 32'(cnt_q) <= FIFO_DEPTH)
endmodule

### sim/tb.sv
// Self-checking testbench of the grid square coverage counter.
`timescale 1ns / 1ps
module tb;
  import gscc_pkg::*;

  localparam logic [3:0] AddrGrid   = {RegGrid, 2'b00};
  localparam logic [3:0] AddrRadius = {RegRadius, 2'b00};
  localparam logic [3:0] AddrLimit  = {RegLimit, 2'b00};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  cmd_t        cmd_i = '0;
  logic        busy_o, done_o;
  res_t        res_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_square_coverage_counter u_top (
    .clk_i, .rst_ni, .start_i, .cmd_i, .busy_o, .done_o, .res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Shadow state of the block.
  bit          global_cov [0:65535];
  bit          sink_cov [0:65535];
  logic [17:0] pos_fifo [0:63];
  int unsigned fifo_rd, fifo_fill;
  logic [8:0]  grid_cfg = GridReset;
  logic [7:0]  radius_cfg = RadiusReset;
  logic [6:0]  limit_cfg = LimitReset;

  res_t pending_reports [$];
  int   errors = 0;

  function automatic int unsigned grid_eff();
    if (grid_cfg == 0) return 1;
    if (grid_cfg > MaxGrid) return MaxGrid;
    return 32'(grid_cfg);
  endfunction

  function automatic int unsigned limit_eff();
    if (limit_cfg == 0) return 1;
    if (limit_cfg > FifoDepth) return FifoDepth;
    return 32'(limit_cfg);
  endfunction

  task automatic paint_square(bit to_sink, int unsigned px, int unsigned py);
    int unsigned g, x0, y0, x1, y1;
    g  = grid_eff();
    x0 = px > radius_cfg ? px - radius_cfg : 0;
    y0 = py > radius_cfg ? py - radius_cfg : 0;
    x1 = px + radius_cfg;
    y1 = py + radius_cfg;
    if (x1 > g) x1 = g;
    if (y1 > g) y1 = g;
    for (int unsigned a = x0; a < x1; a++)
      for (int unsigned b = y0; b < y1; b++)
        if (to_sink) sink_cov[a*MaxGrid+b] = 1'b1;
        else global_cov[a*MaxGrid+b] = 1'b1;
  endtask

  function automatic longint unsigned tally_map(bit from_sink);
    longint unsigned n;
    n = 0;
    for (int unsigned a = 0; a < grid_eff(); a++)
      for (int unsigned b = 0; b < grid_eff(); b++)
        n += from_sink ? sink_cov[a*MaxGrid+b] : global_cov[a*MaxGrid+b];
    return n;
  endfunction

  task automatic apply_coverage(cmd_t c);
    longint unsigned total, gc, bc, rel, skip;
    logic [17:0] e;
    res_t r;
    case (c.opcode)
      OpClear: begin
        foreach (global_cov[i]) begin
          global_cov[i] = 1'b0;
          sink_cov[i] = 1'b0;
        end
        fifo_rd = 0;
        fifo_fill = 0;
      end
      OpMark: paint_square(1'b0, 32'(c.x_pos), 32'(c.y_pos));
      OpPacket: begin
        while (fifo_fill >= limit_eff()) begin
          fifo_rd = (fifo_rd + 1) % FifoDepth;
          fifo_fill--;
        end
        pos_fifo[(fifo_rd + fifo_fill) % FifoDepth] = {c.x_pos, c.y_pos};
        fifo_fill++;
      end
      default: begin
        skip = fifo_fill > limit_eff() ? fifo_fill - limit_eff() : 0;
        for (longint unsigned k = skip; k < fifo_fill; k++) begin
          e = pos_fifo[(fifo_rd + k) % FifoDepth];
          paint_square(1'b1, 32'(e[17:9]), 32'(e[8:0]));
        end
        fifo_rd = 0;
        fifo_fill = 0;
        total = grid_eff() * grid_eff();
        gc = tally_map(1'b0);
        bc = tally_map(1'b1);
        rel = 0;
        if (gc != 0) begin
          rel = bc * FullQ8 / gc;
          if (rel > FullQ8) rel = FullQ8;
        end
        r.global_cells     = gc[16:0];
        r.buffered_cells   = bc[16:0];
        r.global_percent   = 15'(gc * FullQ8 / total);
        r.buffered_percent = 15'(bc * FullQ8 / total);
        r.relative_percent = rel[14:0];
        r.relative_valid   = gc != 0;
        pending_reports.push_back(r);
      end
    endcase
  endtask

  // Send one command: random gap, then hold start until accepted.
  task automatic issue_cmd(logic [1:0] op, int unsigned x, int unsigned y);
    int unsigned gap;
    cmd_t c;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    c.opcode = op;
    c.x_pos = 9'(x);
    c.y_pos = 9'(y);
    start_i <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy_o);
    apply_coverage(c);
  endtask

  // Drop start and wait until the block is idle with nothing outstanding.
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (busy_o || pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [3:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      AddrGrid:   grid_cfg = data[8:0];
      AddrRadius: radius_cfg = data[7:0];
      default:    limit_cfg = data[6:0];
    endcase
    // hold the bus idle between transfers
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [8:0] g, logic [7:0] r, logic [6:0] l);
    apb_write(AddrGrid, 32'(g));
    apb_write(AddrRadius, 32'(r));
    apb_write(AddrLimit, 32'(l));
  endtask

  task automatic test_defaults();
    issue_cmd(OpFinish, 0, 0);
    issue_cmd(OpMark, 50, 50);
    issue_cmd(OpPacket, 50, 50);
    issue_cmd(OpPacket, 0, 0);
    issue_cmd(OpFinish, 0, 0);
    issue_cmd(OpMark, 511, 511);
    issue_cmd(OpFinish, 0, 0);
    issue_cmd(OpClear, 0, 0);
    issue_cmd(OpFinish, 0, 0);
    settle();
  endtask

  task automatic test_extremes();
    set_config(9'd511, 8'd255, 7'd1);
    issue_cmd(OpMark, 0, 0);
    issue_cmd(OpMark, 511, 0);
    issue_cmd(OpPacket, 128, 128);
    issue_cmd(OpPacket, 300, 5);
    issue_cmd(OpFinish, 0, 0);
    settle();
    set_config(9'd0, 8'd0, 7'd0);
    issue_cmd(OpMark, 0, 0);
    issue_cmd(OpPacket, 0, 0);
    issue_cmd(OpFinish, 0, 0);
    settle();
  endtask

  task automatic test_limit_and_shrink();
    set_config(9'd8, 8'd1, 7'd127);
    issue_cmd(OpPacket, 1, 1);
    issue_cmd(OpPacket, 2, 6);
    issue_cmd(OpPacket, 5, 3);
    issue_cmd(OpPacket, 7, 0);
    settle();
    apb_write(AddrLimit, 2);
    issue_cmd(OpPacket, 3, 3);
    issue_cmd(OpMark, 7, 7);
    issue_cmd(OpFinish, 0, 0);
    settle();
    apb_write(AddrGrid, 4);
    issue_cmd(OpFinish, 0, 0);
    settle();
    apb_write(AddrGrid, 8);
    issue_cmd(OpFinish, 0, 0);
    settle();
  endtask

  // Random traffic; finish_pct shapes the operation mix.
  task automatic run_random(int n, int unsigned gmax, int unsigned rmax, int finish_pct);
    int unsigned g, d;
    logic [1:0] op;
    int unsigned x, y;
    g = $urandom_range(1, gmax);
    set_config(g[8:0], 8'($urandom_range(0, rmax)), 7'($urandom_range(0, 70)));
    for (int i = 0; i < n; i++) begin
      d = $urandom_range(0, 999);
      if (d < 3) op = OpClear;
      else if (d < 3 + finish_pct * 10) op = OpFinish;
      else if (d < 500) op = OpMark;
      else op = OpPacket;
      if ($urandom_range(0, 1)) begin
        x = $urandom_range(0, 511);
        y = $urandom_range(0, 511);
      end else begin
        x = $urandom_range(0, g + 2);
        y = $urandom_range(0, g + 2);
      end
      issue_cmd(op, x, y);
    end
    settle();
  endtask

  task automatic test_random();
    run_random(30, 256, 3, 3);
    for (int p = 0; p < 15; p++)
      run_random(105, $urandom_range(0, 3) == 0 ? 32 : 12, $urandom_range(0, 1) ? 255 : 6, 15);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected result: actual %p", $time, res_o);
        errors++;
      end else begin
        res_t want;
        want = pending_reports.pop_front();
        if (res_o.global_cells !== want.global_cells) begin
          $display("%0t global_cells expected %0d actual %0d", $time,
                   want.global_cells, res_o.global_cells);
          errors++;
        end
        if (res_o.buffered_cells !== want.buffered_cells) begin
          $display("%0t buffered_cells expected %0d actual %0d", $time,
                   want.buffered_cells, res_o.buffered_cells);
          errors++;
        end
        if (res_o.global_percent !== want.global_percent) begin
          $display("%0t global_percent expected %0d actual %0d", $time,
                   want.global_percent, res_o.global_percent);
          errors++;
        end
        if (res_o.buffered_percent !== want.buffered_percent) begin
          $display("%0t buffered_percent expected %0d actual %0d", $time,
                   want.buffered_percent, res_o.buffered_percent);
          errors++;
        end
        if (res_o.relative_percent !== want.relative_percent) begin
          $display("%0t relative_percent expected %0d actual %0d", $time,
                   want.relative_percent, res_o.relative_percent);
          errors++;
        end
        if (res_o.relative_valid !== want.relative_valid) begin
          $display("%0t relative_valid expected %0d actual %0d", $time,
                   want.relative_valid, res_o.relative_valid);
          errors++;
        end
      end
    end
  end

  initial begin
    fifo_rd = 0;
    fifo_fill = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_extremes();
    test_limit_and_shrink();
    test_random();
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
